// ===== sv/scr_pkg.sv =====
// Package for the sector cache tag and clock replacement engine.
// Holds payload widths and parameter defaults; no dependencies.
package scr_pkg;

   localparam int ENTRY_COUNT_DEF = 64;
   localparam int SECTOR_BITS_DEF = 32;

   localparam int SECTOR_W = 32;
   localparam int ENTRY_W  = 6;

endpackage

// ===== sv/scr_if.sv =====
// Request and response channel interfaces of the sector cache engine.
// Depends on scr_pkg for the payload widths.
interface scr_req_if import scr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [SECTOR_W-1:0] sector;

   modport source (output valid, output op, output sector, input ready);
   modport sink   (input valid, input op, input sector, output ready);
endinterface

interface scr_rsp_if import scr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [ENTRY_W-1:0]  entry;
   logic                evict_dirty;
   logic [SECTOR_W-1:0] evict_sector;

   modport source (output valid, output hit, output entry, output evict_dirty,
                   output evict_sector, input ready);
   modport sink   (input valid, input hit, input entry, input evict_dirty,
                   input evict_sector, output ready);
endinterface

// ===== sv/sector_cache_clock_replacement.sv =====
// Tag and clock replacement engine of a fully associative sector cache.
// Depends on scr_pkg and the channel interfaces in scr_if.sv.
//
// One transaction is processed at a time. Tags, dirty and used marks live in
// one synchronous memory of ENTRY_COUNT words, read and written once a cycle;
// valid marks are flip-flops cleared at reset, so no clearing pass is needed.
// The tag search reads the memory one entry per cycle from entry 0 and stops
// at the first hit. A miss searches all entries, then the clock sweep reads
// one entry per cycle from the hand, clearing used marks until it reaches an
// unused or invalid entry; it skips at most ENTRY_COUNT used entries. A
// finished result sits in the output register while the next request is
// accepted.
module sector_cache_clock_replacement
   import scr_pkg::*;
#(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
   parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   scr_req_if.sink   req_bus,
   scr_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(ENTRY_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [SECTOR_BITS-1:0] tag;
      logic                   dirty;
      logic                   used;
   } word_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   word_type mem [ENTRY_COUNT];

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic [SECTOR_BITS-1:0] sec_ff, sec_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   issue_ff, issue_in;
   logic                   rd_live_ff, rd_live_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   word_type               rd_data_ff;
   logic [ENTRY_COUNT-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       hand_ff, hand_in;

   logic                   res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   logic                   res_evd_ff, res_evd_in;
   logic [SECTOR_W-1:0]    res_evs_ff, res_evs_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [ENTRY_W-1:0]     rsp_entry_ff, rsp_entry_in;
   logic                   rsp_evd_ff, rsp_evd_in;
   logic [SECTOR_W-1:0]    rsp_evs_ff, rsp_evs_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   word_type               wr_data;
   logic                   rd_valid;
   logic                   match;
   logic                   used_now;
   logic                   victim_now;

   assign rd_valid   = valid_ff[rd_idx_ff];
   assign match      = rd_live_ff && rd_valid && (rd_data_ff.tag == sec_ff);
   assign used_now   = rd_valid && rd_data_ff.used;
   assign victim_now = (state_ff == ST_SWEEP) && rd_live_ff && !used_now;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sec_in       = sec_ff;
      scan_in      = scan_ff;
      issue_in     = issue_ff;
      hand_in      = hand_ff;
      valid_in     = valid_ff;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      res_evd_in   = res_evd_ff;
      res_evs_in   = res_evs_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_evd_in   = rsp_evd_ff;
      rsp_evs_in   = rsp_evs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_en        = 1'b0;
      rd_addr      = scan_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.op;
               sec_in   = SECTOR_BITS'(req_bus.sector);
               scan_in  = '0;
               issue_in = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (issue_ff) begin
               rd_en = 1'b1;
               if (scan_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (match) begin
               wr_en         = 1'b1;
               wr_data.dirty = rd_data_ff.dirty | op_ff;
               wr_data.used  = 1'b1;
               res_hit_in    = 1'b1;
               res_idx_in    = rd_idx_ff;
               res_evd_in    = 1'b0;
               res_evs_in    = '0;
               issue_in      = 1'b0;
               state_in      = ST_DONE;
            end else if (rd_live_ff && rd_idx_ff == LAST_IDX) begin
               scan_in  = hand_ff;
               issue_in = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (issue_ff) begin
               rd_en   = 1'b1;
               scan_in = next_idx(scan_ff);
            end
            if (rd_live_ff) begin
               wr_en = 1'b1;
               if (used_now) begin
                  wr_data.used = 1'b0;
               end else begin
                  wr_data.tag          = sec_ff;
                  wr_data.dirty        = op_ff;
                  wr_data.used         = 1'b1;
                  valid_in[rd_idx_ff]  = 1'b1;
                  hand_in              = next_idx(rd_idx_ff);
                  res_hit_in           = 1'b0;
                  res_idx_in           = rd_idx_ff;
                  res_evd_in           = rd_valid && rd_data_ff.dirty;
                  res_evs_in           = (rd_valid && rd_data_ff.dirty) ?
                                         SECTOR_W'(rd_data_ff.tag) : '0;
                  issue_in             = 1'b0;
                  state_in             = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_entry_in = ENTRY_W'(res_idx_ff);
               rsp_evd_in   = res_evd_ff;
               rsp_evs_in   = res_evs_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_live_in = rd_en;
      rd_idx_in  = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_live_ff   <= 1'b0;
         valid_ff     <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_live_ff   <= rd_live_in;
         valid_ff     <= valid_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sec_ff       <= sec_in;
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      res_hit_ff   <= res_hit_in;
      res_idx_ff   <= res_idx_in;
      res_evd_ff   <= res_evd_in;
      res_evs_ff   <= res_evs_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_evd_ff   <= rsp_evd_in;
      rsp_evs_ff   <= rsp_evs_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.entry        = rsp_entry_ff;
   assign rsp_bus.evict_dirty  = rsp_evd_ff;
   assign rsp_bus.evict_sector = rsp_evs_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("memory write and read target the same entry");

   a_hand_past_victim: assert property (@(posedge clock) disable iff (reset)
      victim_now |=> (hand_ff == next_idx($past(rd_idx_ff))))
      else $error("clock hand not one past the victim");

   a_refill_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_hit_ff) |-> valid_ff[res_idx_ff])
      else $error("refilled entry not marked valid");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.hit) |->
         (!rsp_bus.evict_dirty && rsp_bus.evict_sector == '0))
      else $error("hit transaction reports an eviction");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for sector_cache_clock_replacement: directed and random sector accesses,
// each result checked against an in-bench tag store and clock-hand predictor.
// Depends on scr_pkg, the channel interfaces in scr_if.sv and the engine RTL.
module testbench;
   import scr_pkg::*;

   localparam int ENTRIES         = ENTRY_COUNT_DEF;
   localparam int POOL_SIZE       = 72;
   localparam int ACCESS_TARGET   = 1800;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 300;
   localparam int PRINT_LIMIT     = 40;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } access_op_type;

   typedef struct {
      access_op_type       op;
      logic [SECTOR_W-1:0] sector;
      bit                  drain_first;
   } access_type;

   typedef struct packed {
      logic                hit;
      logic [ENTRY_W-1:0]  entry;
      logic                evict_dirty;
      logic [SECTOR_W-1:0] evict_sector;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_hold = 1'b0;

   scr_req_if req_bus ();
   scr_rsp_if rsp_bus ();

   sector_cache_clock_replacement uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // predictor state
   logic [SECTOR_W-1:0] tag_mem [ENTRIES];
   bit                  valid_mark [ENTRIES];
   bit                  dirty_mark [ENTRIES];
   bit                  used_mark [ENTRIES];
   int                  hand_pos = 0;

   access_type access_q[$];
   lookup_type lookup_results_q[$];
   access_type offered;
   lookup_type want;

   int phase_len = 0;
   int accepted_count = 0;
   int result_count = 0;
   int error_count = 0;
   int hit_count = 0;
   int refill_count = 0;
   int writeback_count = 0;
   int full_turn_count = 0;

   function automatic lookup_type cache_lookup(access_type acc);
      lookup_type res;
      int         slot;
      int         i;
      int         swept;
      res  = '0;
      slot = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (slot < 0 && valid_mark[i] && tag_mem[i] == acc.sector) slot = i;
      end
      if (slot >= 0) begin
         res.hit = 1'b1;
         used_mark[slot] = 1'b1;
         if (acc.op == OP_WRITE) dirty_mark[slot] = 1'b1;
         hit_count++;
      end else begin
         slot  = hand_pos;
         swept = 0;
         while (used_mark[slot]) begin
            used_mark[slot] = 1'b0;
            swept++;
            slot = (slot + 1) % ENTRIES;
         end
         if (swept == ENTRIES) full_turn_count++;
         hand_pos = (slot + 1) % ENTRIES;
         if (valid_mark[slot] && dirty_mark[slot]) begin
            res.evict_dirty  = 1'b1;
            res.evict_sector = tag_mem[slot];
            writeback_count++;
         end
         tag_mem[slot]    = acc.sector;
         valid_mark[slot] = 1'b1;
         used_mark[slot]  = 1'b1;
         dirty_mark[slot] = (acc.op == OP_WRITE);
         refill_count++;
      end
      res.entry = ENTRY_W'(slot);
      return res;
   endfunction

   function automatic int send_idle_pct(int n);
      if (n < phase_len) return 20;
      if (n < 2 * phase_len) return 54;
      return 0;
   endfunction

   function automatic int recv_idle_pct(int n);
      if (n < phase_len) return 54;
      if (n < 2 * phase_len) return 20;
      return 0;
   endfunction

   task automatic report(string what, logic [SECTOR_W-1:0] got, logic [SECTOR_W-1:0] exp_val);
      if (error_count < PRINT_LIMIT)
         $display("%0t: result %0d %s: got 'h%0h, expected 'h%0h",
                  $realtime, result_count, what, got, exp_val);
      error_count++;
   endtask

   task automatic queue_access(bit wr, logic [SECTOR_W-1:0] sector);
      access_type acc;
      acc.op          = wr ? OP_WRITE : OP_READ;
      acc.sector      = sector;
      acc.drain_first = 1'b0;
      access_q.push_back(acc);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            lookup_results_q.push_back(cache_lookup(offered));
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (access_q.size() != 0
                && !(access_q[0].drain_first
                     && (accepted_count + (req_bus.valid && req_bus.ready) != result_count))
                && $urandom_range(99) >= send_idle_pct(accepted_count)) begin
               offered = access_q.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.op     <= offered.op;
               req_bus.sector <= offered.sector;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count <= result_count + 1;
            if (lookup_results_q.size() == 0) begin
               report("transaction with nothing pending", SECTOR_W'(rsp_bus.entry), '0);
            end else begin
               want = lookup_results_q.pop_front();
               if (rsp_bus.hit !== want.hit)
                  report("hit", SECTOR_W'(rsp_bus.hit), SECTOR_W'(want.hit));
               if (rsp_bus.entry !== want.entry)
                  report("entry", SECTOR_W'(rsp_bus.entry), SECTOR_W'(want.entry));
               if (rsp_bus.evict_dirty !== want.evict_dirty)
                  report("evict_dirty", SECTOR_W'(rsp_bus.evict_dirty),
                         SECTOR_W'(want.evict_dirty));
               if (rsp_bus.evict_sector !== want.evict_sector)
                  report("evict_sector", rsp_bus.evict_sector, want.evict_sector);
            end
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct(accepted_count));
      end
   end

   // long response hold-off while the sender keeps offering
   initial begin
      wait (phase_len > 0 && accepted_count >= 2 * phase_len + 100);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #8_000_000;
      $display("sector_cache_clock_replacement verification failed");
      $finish;
   end

   initial begin
      logic [SECTOR_W-1:0] pool [POOL_SIZE];
      int                  mode;
      int                  len;
      int                  k;
      int                  start;
      int                  pass;
      req_bus.valid  = 1'b0;
      req_bus.op     = OP_READ;
      req_bus.sector = '0;
      rsp_bus.ready  = 1'b0;

      queue_access(1'b0, 32'h0000_0000);
      queue_access(1'b1, 32'hFFFF_FFFF);
      queue_access(1'b0, 32'h0000_0000);
      queue_access(1'b1, 32'h0000_0000);
      queue_access(1'b0, 32'hFFFF_FFFF);
      queue_access(1'b1, 32'h8000_0000);
      queue_access(1'b0, 32'h7FFF_FFFF);
      queue_access(1'b1, 32'hAAAA_AAAA);
      queue_access(1'b0, 32'h5555_5555);
      queue_access(1'b1, 32'h0000_0001);
      queue_access(1'b0, 32'hFFFF_FFFE);
      queue_access(1'b0, 32'h8000_0000);
      queue_access(1'b1, 32'h7FFF_FFFF);
      queue_access(1'b0, 32'h0000_0000);
      queue_access(1'b1, 32'h0000_0001);
      queue_access(1'b0, 32'hAAAA_AAAA);

      for (k = 0; k < POOL_SIZE; k++) pool[k] = $urandom;
      while (access_q.size() < ACCESS_TARGET) begin
         mode = $urandom_range(0, 9);
         if (mode <= 5) begin
            len = $urandom_range(16, 48);
            repeat (len)
               queue_access(1'($urandom_range(0, 1)),
                            pool[$urandom_range(0, POOL_SIZE - 1)]);
         end else if (mode <= 8) begin
            len = $urandom_range(4, 16);
            repeat (len) begin
               if ($urandom_range(0, 1))
                  queue_access(1'($urandom_range(0, 1)), $urandom);
               else
                  queue_access(1'($urandom_range(0, 1)),
                               pool[$urandom_range(0, POOL_SIZE - 1)]
                               ^ (32'h1 << $urandom_range(0, 31)));
            end
         end else begin
            // touch a full working set until every entry is used, then miss
            start = $urandom_range(0, ENTRIES - 1);
            for (pass = 0; pass < 3; pass++)
               for (k = 0; k < ENTRIES; k++)
                  queue_access(1'($urandom_range(0, 1)), pool[(start + k) % ENTRIES]);
            queue_access(1'($urandom_range(0, 1)), $urandom);
         end
      end
      phase_len = access_q.size() / 3;
      access_q[phase_len].drain_first = 1'b1;
      access_q[2 * phase_len].drain_first = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (access_q.size() != 0 || req_bus.valid || lookup_results_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lookup_results_q.size() != 0)
         report("transactions never answered", SECTOR_W'(lookup_results_q.size()), '0);

      $display("%0d accesses checked: %0d hits, %0d refills, %0d dirty write-backs, %0d full hand turns",
               result_count, hit_count, refill_count, writeback_count, full_turn_count);
      $display("idle mixes 20/54, 54/20 and none, two drains, one %0d-cycle response hold-off",
               RSP_HOLD_CYCLES);
      if (error_count == 0) begin
         $display("sector_cache_clock_replacement verification clean");
      end else begin
         $display("sector_cache_clock_replacement verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/scr_pkg.sv
sv/scr_if.sv
sv/sector_cache_clock_replacement.sv
tb/sv/testbench.sv
